### rtl/mtf_pkg.sv
// shared types and constants of the move-to-front coder
package mtf_pkg;

    localparam int VALUE_W           = 8;
    localparam int DEF_ALPHABET_SIZE = 95;
    localparam int DEF_LOWEST_SYMBOL = 32;

    typedef logic [VALUE_W-1:0] t_value;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REBUILD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic search_step;
        logic rebuild_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_oor;
        logic cnt_last;
        logic hit;
        logic out_busy;
    } t_ctrl_sts;

endpackage

### rtl/mtf_if.sv
// request, result and configuration channels of the move-to-front coder
interface mtf_item_if import mtf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value_in;
    logic   block_start;

    modport source (output valid, value_in, block_start, input ready);
    modport sink   (input valid, value_in, block_start, output ready);
endinterface

interface mtf_result_if import mtf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value_out;
    logic   bad_item;

    modport source (output valid, value_out, bad_item, input ready);
    modport sink   (input valid, value_out, bad_item, output ready);
endinterface

interface mtf_cfg_if;
    logic valid;
    logic ready;
    logic decode_mode;

    modport source (output valid, decode_mode, input ready);
    modport sink   (input valid, decode_mode, output ready);
endinterface

### rtl/mtf_ctrl.sv
// sequencing state machine of the move-to-front coder
module mtf_ctrl import mtf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_oor ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.cnt_last) begin
                    n_state = i_sts.hit ? ST_REBUILD : ST_DONE;
                end
            end
            ST_REBUILD: begin
                if (i_sts.cnt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_SEARCH:  o_cmd.search_step  = 1'b1;
            ST_REBUILD: o_cmd.rebuild_step = 1'b1;
            ST_DONE:    o_cmd.load_out     = !i_sts.out_busy;
            default:    o_cmd              = '0;
        endcase
    end

endmodule

### rtl/mtf_dpath.sv
// symbol list as a rotating cell line, search and rebuild datapath, result register
module mtf_dpath import mtf_pkg::*; #(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int LOWEST_SYMBOL = DEF_LOWEST_SYMBOL
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctrl_cmd i_cmd,
    output t_ctrl_sts o_sts,
    input  t_value    i_value_in,
    input  logic      i_block_start,
    input  logic      i_cfg_valid,
    input  logic      i_decode_mode,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_value    o_value_out,
    output logic      o_bad_item
);

    localparam int CW      = $clog2(ALPHABET_SIZE);
    localparam int TOP_SYM = LOWEST_SYMBOL + ALPHABET_SIZE - 1;

    t_value          r_cell [ALPHABET_SIZE];
    logic            r_decode_mode;
    t_value          r_val_in;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic [CW-1:0]   r_pos;
    t_value          r_sym;
    t_value          r_prev;
    logic            r_found;
    logic            r_out_valid;
    t_value          r_out_value;
    logic            r_out_bad;

    t_value          head;
    t_value          tail_in;
    logic            match;
    logic            cnt_last;

    assign head     = r_cell[0];
    assign cnt_last = (r_cnt == CW'(ALPHABET_SIZE - 1));
    assign n_cnt    = cnt_last ? '0 : r_cnt + 1'b1;
    assign match    = r_decode_mode ? (r_cnt == r_pos) : (head == r_val_in);

    // rebuilt order: found symbol, entries ahead of it, then the rest with it skipped
    always_comb begin
        priority if (r_cnt == '0) begin
            tail_in = r_sym;
        end else if (r_cnt <= r_pos) begin
            tail_in = r_prev;
        end else begin
            tail_in = head;
        end
    end

    assign o_sts.in_oor   = r_decode_mode && (i_value_in >= VALUE_W'(ALPHABET_SIZE));
    assign o_sts.cnt_last = cnt_last;
    assign o_sts.hit      = r_found | match;
    assign o_sts.out_busy = r_out_valid & !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                r_cell[i] <= VALUE_W'(TOP_SYM - i);
            end
            r_decode_mode <= 1'b0;
            r_cnt         <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_decode_mode <= i_decode_mode;
            end

            if (i_cmd.accept) begin
                r_val_in <= i_value_in;
                r_pos    <= i_value_in[CW-1:0];
                r_cnt    <= '0;
                r_found  <= 1'b0;
                if (i_block_start) begin
                    for (int i = 0; i < ALPHABET_SIZE; i++) begin
                        r_cell[i] <= VALUE_W'(TOP_SYM - i);
                    end
                end
            end

            // search pass: plain rotation, list comes back to its place
            if (i_cmd.search_step) begin
                for (int i = 0; i < ALPHABET_SIZE - 1; i++) begin
                    r_cell[i] <= r_cell[i+1];
                end
                r_cell[ALPHABET_SIZE-1] <= head;
                r_cnt <= n_cnt;
                if (match && !r_found) begin
                    r_found <= 1'b1;
                    r_pos   <= r_cnt;
                    r_sym   <= head;
                end
            end

            if (i_cmd.rebuild_step) begin
                for (int i = 0; i < ALPHABET_SIZE - 1; i++) begin
                    r_cell[i] <= r_cell[i+1];
                end
                r_cell[ALPHABET_SIZE-1] <= tail_in;
                r_prev <= head;
                r_cnt  <= n_cnt;
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_out_bad   <= !r_found;
                if (!r_found) begin
                    r_out_value <= '0;
                end else if (r_decode_mode) begin
                    r_out_value <= r_sym;
                end else begin
                    r_out_value <= VALUE_W'(r_pos);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_bad_item  = r_out_bad;

endmodule

### rtl/move_to_front_coder.sv
// move-to-front coder: top level
//
// channels: i_item takes one request (value_in, block_start); o_result gives one
// result (value_out, bad_item) per request; i_cfg writes decode_mode and is always
// ready. all use valid/ready, a transfer happens when both are high.
// encode: value_in is a symbol byte, value_out its list position.
// decode: value_in is a list position, value_out the symbol held there.
// block_start restores the initial list ('~' down to ' ') before the request.
// the list is a line of cells rotated through one head cell. a request takes a
// search rotation through every cell and, when the symbol is found, a rebuild
// rotation through every cell again; the result is then registered once the
// result register is free. an unknown symbol skips the rebuild, and a decode
// position out of range skips both rotations.
// a new request is taken in the idle state that follows the result load.
// reset loads the initial list and clears decode_mode to encode.
// a stalled receiver holds the result register; the next request may still be
// taken and worked, and waits at the end until the register frees.
module move_to_front_coder import mtf_pkg::*; #(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int LOWEST_SYMBOL = DEF_LOWEST_SYMBOL
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mtf_item_if.sink     i_item,
    mtf_result_if.source o_result,
    mtf_cfg_if.sink      i_cfg
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;
    logic      in_ready;

    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    mtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mtf_dpath #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .LOWEST_SYMBOL (LOWEST_SYMBOL)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_value_in    (i_item.value_in),
        .i_block_start (i_item.block_start),
        .i_cfg_valid   (i_cfg.valid),
        .i_decode_mode (i_cfg.decode_mode),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_value_out   (o_result.value_out),
        .o_bad_item    (o_result.bad_item)
    );

endmodule

### rtl/mtf_checker.sv
// port-level checks of the move-to-front coder and their binding
module mtf_checker import mtf_pkg::*; #(
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
    parameter int LOWEST_SYMBOL = DEF_LOWEST_SYMBOL
) (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_value i_value_out,
    input logic   i_bad_item
);

    localparam int TOP_SYM = LOWEST_SYMBOL + ALPHABET_SIZE - 1;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value_out)
            && $stable(i_bad_item))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_item |-> i_value_out == '0)
        else $error("bad request with non-zero value");

    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_bad_item |->
            (i_value_out < VALUE_W'(ALPHABET_SIZE))
            || (i_value_out >= VALUE_W'(LOWEST_SYMBOL) && i_value_out <= VALUE_W'(TOP_SYM)))
        else $error("result outside position and symbol ranges");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in flight");

endmodule

bind move_to_front_coder mtf_checker #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .LOWEST_SYMBOL (LOWEST_SYMBOL)
) u_mtf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_value_out (o_result.value_out),
    .i_bad_item  (o_result.bad_item)
);

### bench/move_to_front_coder_tb.sv
// self-checking bench for the move-to-front coder, encode and decode with random flow control
`timescale 1ns / 1ps

module move_to_front_coder_tb;
    import mtf_pkg::*;

    localparam int ALPHABET_SIZE  = DEF_ALPHABET_SIZE;
    localparam int LOWEST_SYMBOL  = DEF_LOWEST_SYMBOL;
    localparam int MAX_LATENCY    = 2 * ALPHABET_SIZE + 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 305;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_coder_mode;

    typedef struct packed {
        t_value value_out;
        logic   bad_item;
    } t_coded_result;

    // list predictor plus queue of results still owed by the block
    class mtf_scoreboard;
        t_value        symbols[ALPHABET_SIZE];
        t_coder_mode   mode;
        t_coded_result owed_results[$];
        int            errors;
        int            n_encoded;
        int            n_decoded;
        int            n_block_starts;
        int            n_uncodable;
        int            n_mode_writes;

        function new();
            mode           = MODE_ENCODE;
            errors         = 0;
            n_encoded      = 0;
            n_decoded      = 0;
            n_block_starts = 0;
            n_uncodable    = 0;
            n_mode_writes  = 0;
            restore_list();
        endfunction

        function void restore_list();
            for (int i = 0; i < ALPHABET_SIZE; i++) begin
                symbols[i] = t_value'(LOWEST_SYMBOL + ALPHABET_SIZE - 1 - i);
            end
        endfunction

        function void set_mode(t_coder_mode m);
            mode = m;
            n_mode_writes++;
        endfunction

        function void move_front(int pos);
            t_value sym;
            sym = symbols[pos];
            for (int i = pos; i > 0; i--) begin
                symbols[i] = symbols[i-1];
            end
            symbols[0] = sym;
        endfunction

        function void note_request(t_value v, logic bs);
            t_coded_result r;
            logic          hit;
            int            pos;
            r   = '0;
            hit = 1'b0;
            pos = 0;
            if (bs) begin
                restore_list();
                n_block_starts++;
            end
            if (mode == MODE_DECODE) begin
                n_decoded++;
                if (v < ALPHABET_SIZE) begin
                    r.value_out = symbols[v];
                    move_front(int'(v));
                end else begin
                    r.bad_item = 1'b1;
                end
            end else begin
                n_encoded++;
                for (int i = 0; i < ALPHABET_SIZE; i++) begin
                    if (!hit && symbols[i] == v) begin
                        hit = 1'b1;
                        pos = i;
                    end
                end
                if (hit) begin
                    r.value_out = t_value'(pos);
                    move_front(pos);
                end else begin
                    r.bad_item = 1'b1;
                end
            end
            if (r.bad_item)
                n_uncodable++;
            owed_results = {owed_results, r};
        endfunction

        function void check_result(t_value v, logic bad);
            t_coded_result r;
            if (owed_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("error: result value_out=%0d bad_item=%0b with no request waiting",
                             v, bad);
            end else begin
                r = owed_results.pop_front();
                if (r.value_out !== v || r.bad_item !== bad) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("error: value_out exp %0d got %0d, bad_item exp %0b got %0b",
                                 r.value_out, v, r.bad_item, bad);
                end
            end
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mtf_item_if   item_ch();
    mtf_result_if result_ch();
    mtf_cfg_if    cfg_ch();

    move_to_front_coder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    mtf_scoreboard sb = new();

    int burst_left  = 0;
    int idle_cycles = 0;
    int cycle_count = 0;
    int stall_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // monitor: note requests and mode writes, check results, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready)
                sb.note_request(item_ch.value_in, item_ch.block_start);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.value_out, result_ch.bad_item);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_mode(t_coder_mode'(cfg_ch.decode_mode));
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("error: no transfer for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: always ready, short random stalls, then long stalls
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 700) % 3)
            0: begin
                result_ch.ready <= 1'b1;
            end
            1: begin
                result_ch.ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left      <= stall_left - 1;
                    result_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left      <= $urandom_range(1, 300);
                    result_ch.ready <= 1'b0;
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    // valid stays high across a burst so it is never dropped and raised in one step
    task automatic offer_request(t_value v, logic bs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 250);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_ch.valid       <= 1'b1;
        item_ch.value_in    <= v;
        item_ch.block_start <= bs;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic write_mode(t_coder_mode m);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.decode_mode <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(t_coder_mode m, int count);
        t_value v;
        logic   bs;
        int     pick;
        drain_results();
        write_mode(m);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            bs   = ($urandom_range(0, 24) == 0);
            if (m == MODE_ENCODE) begin
                // a small working set keeps symbols near the front
                if (pick < 30)
                    v = t_value'($urandom_range(97, 104));
                else if (pick < 88)
                    v = t_value'($urandom_range(LOWEST_SYMBOL, LOWEST_SYMBOL + ALPHABET_SIZE - 1));
                else
                    v = t_value'($urandom_range(0, 255));
            end else begin
                if (pick < 35)
                    v = t_value'($urandom_range(0, 7));
                else if (pick < 85)
                    v = t_value'($urandom_range(0, ALPHABET_SIZE - 1));
                else
                    v = t_value'($urandom_range(0, 255));
            end
            offer_request(v, bs);
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.value_in    <= '0;
        item_ch.block_start <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.decode_mode  <= MODE_ENCODE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode corners: front and back of the list, repeats, unknown bytes
        write_mode(MODE_ENCODE);
        offer_request(8'd126, 1'b1);
        offer_request(8'd32, 1'b0);
        offer_request(8'd32, 1'b0);
        offer_request(8'd0, 1'b0);
        offer_request(8'd255, 1'b0);
        offer_request(8'd31, 1'b0);
        offer_request(8'd127, 1'b0);
        offer_request(8'd65, 1'b0);
        offer_request(8'd65, 1'b1);
        offer_request(8'd200, 1'b1);
        offer_request(8'd128, 1'b0);
        drain_results();

        // decode corners: first and last position, out of range, block start
        write_mode(MODE_DECODE);
        offer_request(8'd0, 1'b1);
        offer_request(8'd94, 1'b0);
        offer_request(8'd94, 1'b0);
        offer_request(8'd95, 1'b0);
        offer_request(8'd255, 1'b0);
        offer_request(8'd47, 1'b0);
        offer_request(8'd0, 1'b0);
        offer_request(8'd1, 1'b1);
        offer_request(8'd170, 1'b1);

        random_phase(MODE_ENCODE, PHASE_ITEMS);
        random_phase(MODE_DECODE, PHASE_ITEMS);
        random_phase(MODE_ENCODE, PHASE_ITEMS);
        random_phase(MODE_DECODE, PHASE_ITEMS);

        drain_results();
        repeat (MAX_LATENCY + 2) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.errors++;

        $display("run covered %0d encode and %0d decode requests, %0d block starts, %0d uncodable",
                 sb.n_encoded, sb.n_decoded, sb.n_block_starts, sb.n_uncodable);
        $display("mode register written %0d times, %0d mismatches", sb.n_mode_writes, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/mtf_pkg.sv
rtl/mtf_if.sv
rtl/mtf_ctrl.sv
rtl/mtf_dpath.sv
rtl/move_to_front_coder.sv
rtl/mtf_checker.sv
bench/move_to_front_coder_tb.sv
